// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BPFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpfm assertion failed");

// Next-cycle implication, disabled during reset
`define BPFM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpfm assertion failed");

`endif

// ===== hw/rtl/bpfm_pkg.sv =====
// Package for the buffer pool frame manager: widths, codes and the
// controller/datapath command and status structs. Depends on nothing.
package bpfm_pkg;

    localparam int FRAME_CAP        = 16;
    localparam int POOL_FRAMES_DEF  = 16;
    localparam int PIN_BITS_DEF     = 16;
    localparam int PAGE_W           = 32;
    localparam int FRAME_W          = 4;
    localparam int STATUS_W         = 3;
    localparam int DCMD_W           = 2;
    localparam int OP_W             = 2;
    localparam int CFG_W            = 5;
    localparam int APB_AW           = 3;
    localparam int APB_DW           = 32;

    localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
    localparam logic [APB_AW-3:0] REG_FRAMES_IN_USE = 1'b0;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_FETCH     = 2'd0;
    localparam logic [OP_W-1:0] OP_UNPIN     = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH     = 2'd2;
    localparam logic [OP_W-1:0] OP_FLUSH_ALL = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOFRAME = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTRES  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PINERR  = 3'd5;

    // Disk commands
    localparam logic [DCMD_W-1:0] DC_NONE  = 2'd0;
    localparam logic [DCMD_W-1:0] DC_WRITE = 2'd1;
    localparam logic [DCMD_W-1:0] DC_READ  = 2'd2;

    typedef struct packed {
        logic load;
        logic search;
        logic act;
        logic emit_read;
        logic fa_step;
        logic emit_none;
    } cmd_t;

    typedef struct packed {
        logic is_flush_all;
        logic idx_last;
        logic out_busy;
        logic act_two;
        logic fa_dirty;
        logic fa_any;
    } stat_t;

endpackage

// ===== hw/rtl/bpfm_if.sv =====
// Request and result channel interfaces of the buffer pool frame manager.
// Depends on bpfm_pkg for field widths.
interface bpfm_req_if;
    logic                            valid;
    logic                            ready;
    logic [bpfm_pkg::OP_W-1:0]       opcode;
    logic [bpfm_pkg::PAGE_W-1:0]     page_id;
    logic                            mark_dirty;

    modport source (output valid, opcode, page_id, mark_dirty, input ready);
    modport sink   (input valid, opcode, page_id, mark_dirty, output ready);
endinterface

interface bpfm_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bpfm_pkg::STATUS_W-1:0]   status;
    logic [bpfm_pkg::FRAME_W-1:0]    frame_index;
    logic [bpfm_pkg::DCMD_W-1:0]     disk_command;
    logic [bpfm_pkg::PAGE_W-1:0]     disk_page;
    logic                            last;

    modport source (output valid, status, frame_index, disk_command, disk_page, last,
                    input ready);
    modport sink   (input valid, status, frame_index, disk_command, disk_page, last,
                    output ready);
endinterface

// ===== hw/rtl/bpfm_ctrl.sv =====
// Sequencer of the frame manager: walks each request through search, action
// and result emission. Depends on bpfm_pkg (cmd_t, stat_t).
module bpfm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bpfm_pkg::stat_t stat,
    output bpfm_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_ACT,
        S_READ,
        S_FA,
        S_FNONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.is_flush_all ? S_FA : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (stat.idx_last)
                    state_next = S_ACT;
            end
            S_ACT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.act    = 1'b1;
                    state_next = stat.act_two ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit_read = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_FA:
            begin
                // hold while a dirty frame waits for the result register
                if (!(stat.fa_dirty && stat.out_busy))
                begin
                    cmd.fa_step = 1'b1;
                    if (stat.idx_last)
                        state_next = (stat.fa_any || stat.fa_dirty) ? S_IDLE : S_FNONE;
                end
            end
            S_FNONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/bpfm_dp.sv =====
// Datapath of the frame manager: frame table, LRU list, counters and the
// result register. Depends on bpfm_pkg (widths, codes, cmd_t, stat_t).
module bpfm_dp #(
    parameter int POOL_FRAMES = bpfm_pkg::POOL_FRAMES_DEF,
    parameter int PIN_BITS    = bpfm_pkg::PIN_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bpfm_pkg::cmd_t                  cmd,
    output bpfm_pkg::stat_t                 stat,
    input  logic [bpfm_pkg::OP_W-1:0]       req_opcode,
    input  logic [bpfm_pkg::PAGE_W-1:0]     req_page_id,
    input  logic                            req_mark_dirty,
    input  logic [bpfm_pkg::CFG_W-1:0]      frames_in_use,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bpfm_pkg::STATUS_W-1:0]   out_status,
    output logic [bpfm_pkg::FRAME_W-1:0]    out_frame_index,
    output logic [bpfm_pkg::DCMD_W-1:0]     out_disk_command,
    output logic [bpfm_pkg::PAGE_W-1:0]     out_disk_page,
    output logic                            out_last
);

    localparam int CAP = (POOL_FRAMES < bpfm_pkg::FRAME_CAP) ? POOL_FRAMES
                                                            : bpfm_pkg::FRAME_CAP;
    localparam int FW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
    localparam logic [FW-1:0]       IDX_LAST = FW'(CAP - 1);

    // Request latch and scan state
    logic [bpfm_pkg::OP_W-1:0]   op_reg;
    logic [bpfm_pkg::PAGE_W-1:0] page_reg;
    logic                        md_reg;
    logic [FW-1:0]               idx_reg;
    logic                        hit_reg;
    logic [FW-1:0]               hit_idx_reg;
    logic [bpfm_pkg::PAGE_W-1:0] vic_page_reg;
    logic                        fa_any_reg;
    logic [FW-1:0]               rd_frame_reg;

    // Frame table and LRU list
    logic [bpfm_pkg::PAGE_W-1:0] frame_page_reg [CAP];
    logic [CAP-1:0]              valid_reg;
    logic [CAP-1:0]              dirty_reg;
    logic [PIN_BITS-1:0]         pins_reg [CAP];
    logic [FW-1:0]               order_reg [CAP];
    logic [CW-1:0]               rcount_reg;
    logic [CW-1:0]               handed_reg;

    logic [CAP-1:0]              valid_next;
    logic [CAP-1:0]              dirty_next;
    logic [PIN_BITS-1:0]         pins_next [CAP];
    logic [FW-1:0]               order_next [CAP];
    logic [CW-1:0]               rcount_next;
    logic [CW-1:0]               handed_next;
    logic                        page_we;
    logic [FW-1:0]               page_wa;

    // Result register
    logic                          out_valid_reg;
    logic [bpfm_pkg::STATUS_W-1:0] out_status_reg;
    logic [bpfm_pkg::FRAME_W-1:0]  out_frame_reg;
    logic [bpfm_pkg::DCMD_W-1:0]   out_dcmd_reg;
    logic [bpfm_pkg::PAGE_W-1:0]   out_dpage_reg;
    logic                          out_last_reg;

    logic                          res_load;
    logic [bpfm_pkg::STATUS_W-1:0] res_status;
    logic [FW-1:0]                 res_frame;
    logic [bpfm_pkg::DCMD_W-1:0]   res_dcmd;
    logic [bpfm_pkg::PAGE_W-1:0]   res_dpage;
    logic                          res_last;

    // Decision terms
    logic [CW-1:0]       tail_pos;
    logic [FW-1:0]       tail_fr;
    logic                use_fresh;
    logic                use_victim;
    logic                vic_dirty;
    logic [FW-1:0]       new_fr;
    logic [PIN_BITS-1:0] pins_h;
    logic [CAP-1:0]      lru_at;
    logic [CAP-1:0]      lru_shift;
    logic [FW-1:0]       lru_removed [CAP];
    logic [FW-1:0]       lru_pushed [CAP];
    logic                scan_match;
    logic                fa_dirty;
    logic [CAP-1:0]      above_idx;
    logic                more_dirty;

    assign tail_pos   = rcount_reg - CW'(1);
    assign tail_fr    = order_reg[tail_pos[FW-1:0]];
    assign use_fresh  = (32'(handed_reg) < 32'(frames_in_use)) && (32'(handed_reg) < CAP);
    assign use_victim = (rcount_reg != '0);
    assign vic_dirty  = valid_reg[tail_fr] && dirty_reg[tail_fr];
    assign new_fr     = use_fresh ? handed_reg[FW-1:0] : tail_fr;
    assign pins_h     = pins_reg[hit_idx_reg];
    assign scan_match = valid_reg[idx_reg] && (frame_page_reg[idx_reg] == page_reg);
    assign fa_dirty   = valid_reg[idx_reg] && dirty_reg[idx_reg];

    // Remove-from-list and push-head views of the LRU order
    always_comb
    begin
        for (int j = 0; j < CAP; j++)
        begin
            lru_at[j] = (32'(rcount_reg) > j) && (order_reg[j] == hit_idx_reg);
        end
        lru_shift[0] = lru_at[0];
        for (int j = 1; j < CAP; j++)
        begin
            lru_shift[j] = lru_shift[j-1] | lru_at[j];
        end
        for (int j = 0; j < CAP; j++)
        begin
            if (lru_shift[j] && (j < CAP - 1))
                lru_removed[j] = order_reg[(j + 1) % CAP];
            else
                lru_removed[j] = order_reg[j];
        end
        lru_pushed[0] = hit_idx_reg;
        for (int j = 1; j < CAP; j++)
        begin
            lru_pushed[j] = order_reg[j-1];
        end
    end

    // Dirty frames beyond the scan index, for the final flag of a flush-all
    always_comb
    begin
        for (int j = 0; j < CAP; j++)
        begin
            above_idx[j] = (j > 32'(idx_reg));
        end
        more_dirty = |(valid_reg & dirty_reg & above_idx);
    end

    // Next table state and first result of the current step
    always_comb
    begin
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        pins_next   = pins_reg;
        order_next  = order_reg;
        rcount_next = rcount_reg;
        handed_next = handed_reg;
        page_we     = 1'b0;
        page_wa     = new_fr;
        res_load    = 1'b0;
        res_status  = bpfm_pkg::ST_DONE;
        res_frame   = '0;
        res_dcmd    = bpfm_pkg::DC_NONE;
        res_dpage   = '0;
        res_last    = 1'b1;

        priority if (cmd.act)
        begin
            res_load = (op_reg != bpfm_pkg::OP_FLUSH_ALL);
            unique case (op_reg)
                bpfm_pkg::OP_FETCH:
                begin
                    if (hit_reg)
                    begin
                        res_frame = hit_idx_reg;
                        if (pins_h == PIN_MAX)
                        begin
                            res_status = bpfm_pkg::ST_PINERR;
                        end
                        else
                        begin
                            if (pins_h == '0)
                            begin
                                order_next  = lru_removed;
                                rcount_next = rcount_reg - CW'(1);
                            end
                            pins_next[hit_idx_reg] = pins_h + PIN_BITS'(1);
                            res_status = bpfm_pkg::ST_HIT;
                        end
                    end
                    else if (use_fresh || use_victim)
                    begin
                        if (use_fresh)
                            handed_next = handed_reg + CW'(1);
                        else
                            rcount_next = rcount_reg - CW'(1);
                        page_we            = 1'b1;
                        valid_next[new_fr] = 1'b1;
                        dirty_next[new_fr] = 1'b0;
                        pins_next[new_fr]  = PIN_BITS'(1);
                        res_status         = bpfm_pkg::ST_LOADED;
                        res_frame          = new_fr;
                        if (!use_fresh && vic_dirty)
                        begin
                            res_dcmd  = bpfm_pkg::DC_WRITE;
                            res_dpage = vic_page_reg;
                            res_last  = 1'b0;
                        end
                        else
                        begin
                            res_dcmd  = bpfm_pkg::DC_READ;
                            res_dpage = page_reg;
                        end
                    end
                    else
                    begin
                        res_status = bpfm_pkg::ST_NOFRAME;
                    end
                end
                bpfm_pkg::OP_UNPIN:
                begin
                    if (!hit_reg)
                    begin
                        res_status = bpfm_pkg::ST_NOTRES;
                    end
                    else
                    begin
                        res_frame = hit_idx_reg;
                        if (md_reg)
                            dirty_next[hit_idx_reg] = 1'b1;
                        if (pins_h == '0)
                        begin
                            res_status = bpfm_pkg::ST_PINERR;
                        end
                        else
                        begin
                            pins_next[hit_idx_reg] = pins_h - PIN_BITS'(1);
                            if ((pins_h == PIN_BITS'(1)) && (32'(rcount_reg) < CAP))
                            begin
                                order_next  = lru_pushed;
                                rcount_next = rcount_reg + CW'(1);
                            end
                        end
                    end
                end
                bpfm_pkg::OP_FLUSH:
                begin
                    if (!hit_reg)
                    begin
                        res_status = bpfm_pkg::ST_NOTRES;
                    end
                    else
                    begin
                        res_frame = hit_idx_reg;
                        if (dirty_reg[hit_idx_reg])
                        begin
                            dirty_next[hit_idx_reg] = 1'b0;
                            res_dcmd  = bpfm_pkg::DC_WRITE;
                            res_dpage = page_reg;
                        end
                    end
                end
                default:
                begin
                    res_load = 1'b0;
                end
            endcase
        end
        else if (cmd.emit_read)
        begin
            res_load   = 1'b1;
            res_status = bpfm_pkg::ST_LOADED;
            res_frame  = rd_frame_reg;
            res_dcmd   = bpfm_pkg::DC_READ;
            res_dpage  = page_reg;
        end
        else if (cmd.fa_step && fa_dirty)
        begin
            dirty_next[idx_reg] = 1'b0;
            res_load   = 1'b1;
            res_frame  = idx_reg;
            res_dcmd   = bpfm_pkg::DC_WRITE;
            res_dpage  = frame_page_reg[idx_reg];
            res_last   = !more_dirty;
        end
        else if (cmd.emit_none)
        begin
            res_load = 1'b1;
        end
        else
        begin
            res_load = 1'b0;
        end
    end

    // Hold control state, table flags, counters and the result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            rcount_reg    <= '0;
            handed_reg    <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            fa_any_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < CAP; j++)
            begin
                pins_reg[j] <= '0;
            end
        end
        else
        begin
            valid_reg  <= valid_next;
            dirty_reg  <= dirty_next;
            pins_reg   <= pins_next;
            rcount_reg <= rcount_next;
            handed_reg <= handed_next;

            // advance the frame scan
            if (cmd.load)
            begin
                idx_reg    <= '0;
                hit_reg    <= 1'b0;
                fa_any_reg <= 1'b0;
            end
            else if (cmd.search || cmd.fa_step)
            begin
                idx_reg <= (idx_reg == IDX_LAST) ? '0 : idx_reg + FW'(1);
                if (cmd.search && scan_match)
                    hit_reg <= 1'b1;
                if (cmd.fa_step && fa_dirty)
                    fa_any_reg <= 1'b1;
            end

            if (res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req_opcode;
            page_reg <= req_page_id;
            md_reg   <= req_mark_dirty;
        end
        if (cmd.search && scan_match)
            hit_idx_reg <= idx_reg;
        if (cmd.search && use_victim && (idx_reg == tail_fr))
            vic_page_reg <= frame_page_reg[idx_reg];
        if (cmd.act)
            rd_frame_reg <= new_fr;
        if (page_we)
            frame_page_reg[page_wa] <= page_reg;
        order_reg <= order_next;
        if (res_load)
        begin
            out_status_reg <= res_status;
            out_frame_reg  <= bpfm_pkg::FRAME_W'(res_frame);
            out_dcmd_reg   <= res_dcmd;
            out_dpage_reg  <= res_dpage;
            out_last_reg   <= res_last;
        end
    end

    always_comb
    begin
        stat.is_flush_all = (req_opcode == bpfm_pkg::OP_FLUSH_ALL);
        stat.idx_last     = (idx_reg == IDX_LAST);
        stat.out_busy     = out_valid_reg && !out_ready;
        stat.act_two      = (op_reg == bpfm_pkg::OP_FETCH) && !hit_reg && !use_fresh
                            && use_victim && vic_dirty;
        stat.fa_dirty     = fa_dirty;
        stat.fa_any       = fa_any_reg;
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_frame_index  = out_frame_reg;
    assign out_disk_command = out_dcmd_reg;
    assign out_disk_page    = out_dpage_reg;
    assign out_last         = out_last_reg;

endmodule

// ===== hw/rtl/buffer_pool_frame_manager_core.sv =====
// Buffer pool frame manager: fetch, unpin, flush and flush-all requests over a
// pool of up to 16 page frames with LRU replacement of unpinned frames. One
// request is worked on at a time. A fetch, unpin or flush takes an accept step,
// a scan of the frame table at one frame per cycle and an action step, plus a
// read result after a dirty eviction. Flush-all scans the table once, one frame
// per cycle, and stalls on each dirty frame while the result register is full.
// The single-port frame table scan sets the rate. Results leave through a
// one-deep output register, so a new request is taken while the last result
// waits. frames_in_use sits at APB byte address 0 and caps how many never-used
// frames may be handed out.
// Depends on bpfm_pkg, bpfm_if, bpfm_ctrl and bpfm_dp.
module buffer_pool_frame_manager_core #(
    parameter int POOL_FRAMES = bpfm_pkg::POOL_FRAMES_DEF,
    parameter int PIN_BITS    = bpfm_pkg::PIN_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfm_pkg::APB_AW-1:0]   paddr,
    input  logic [bpfm_pkg::APB_DW-1:0]   pwdata,
    output logic [bpfm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    bpfm_req_if.sink                      req,
    bpfm_rsp_if.source                    rsp
);

    logic [bpfm_pkg::CFG_W-1:0] frames_in_use_reg;
    logic                       cfg_hit;
    bpfm_pkg::cmd_t             cmd;
    bpfm_pkg::stat_t            stat;

    // Decode the register window
    assign cfg_hit = (paddr[bpfm_pkg::APB_AW-1:2] == bpfm_pkg::REG_FRAMES_IN_USE)
                     && (paddr[1:0] == 2'b00);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? bpfm_pkg::APB_DW'(frames_in_use_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frames_in_use_reg <= bpfm_pkg::CFG_RESET;
        else if (psel && penable && pwrite && cfg_hit)
            frames_in_use_reg <= pwdata[bpfm_pkg::CFG_W-1:0];
    end

    bpfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpfm_dp #(
        .POOL_FRAMES (POOL_FRAMES),
        .PIN_BITS    (PIN_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .req_opcode       (req.opcode),
        .req_page_id      (req.page_id),
        .req_mark_dirty   (req.mark_dirty),
        .frames_in_use    (frames_in_use_reg),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_status       (rsp.status),
        .out_frame_index  (rsp.frame_index),
        .out_disk_command (rsp.disk_command),
        .out_disk_page    (rsp.disk_page),
        .out_last         (rsp.last)
    );

endmodule

// ===== hw/rtl/bpfm_checker.sv =====
// Port-level checker for the frame manager core and its bind.
// Depends on bpfm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpfm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [bpfm_pkg::STATUS_W-1:0] rsp_status,
    input logic [bpfm_pkg::PAGE_W-1:0]   rsp_disk_page,
    input logic                          rsp_last
);

    // A stalled result holds its payload
    `BPFM_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_disk_page) && $stable(rsp_last))

    // One request at a time: no accept right after an accept
    `BPFM_ASSERT_NXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)

    // When idle, a pending result closes its request
    `BPFM_ASSERT_IMP(a_idle_last, clk, rst_n, req_ready && rsp_valid, rsp_last)

endmodule

bind buffer_pool_frame_manager_core bpfm_checker u_bpfm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_disk_page (rsp.disk_page),
    .rsp_last      (rsp.last)
);

// ===== bench/tb.sv =====
// Testbench for buffer_pool_frame_manager_core: random and directed page requests
// checked against a frame-table and LRU predictor in a scoreboard class.
// Depends on bpfm_pkg, bpfm_if and the core RTL.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [bpfm_pkg::STATUS_W-1:0] status;
        logic [bpfm_pkg::FRAME_W-1:0]  frame_index;
        logic [bpfm_pkg::DCMD_W-1:0]   disk_command;
        logic [bpfm_pkg::PAGE_W-1:0]   disk_page;
        logic                          last;
    } page_result_t;

    // Frame table predictor and queue of expected results
    class frame_scoreboard;
        logic [bpfm_pkg::PAGE_W-1:0] page_of[16];
        bit                resident[16];
        int unsigned       pins[16];
        bit                dirty[16];
        logic [3:0]        recency[16];
        int unsigned       recency_len;
        int unsigned       handed_out;
        int unsigned       frames_allowed;
        page_result_t      pending_results[$];
        int                errors;

        function void clear();
            for (int i = 0; i < 16; i++)
            begin
                resident[i] = 0;
                pins[i] = 0;
                dirty[i] = 0;
            end
            recency_len = 0;
            handed_out = 0;
            frames_allowed = 16;
            errors = 0;
        endfunction

        function void set_frames(int unsigned v);
            frames_allowed = v & 31;
        endfunction

        function void push(logic [bpfm_pkg::STATUS_W-1:0] st, int fr,
                           logic [bpfm_pkg::DCMD_W-1:0] dc,
                           logic [bpfm_pkg::PAGE_W-1:0] pg, bit lst);
            page_result_t r;
            r.status = st;
            r.frame_index = fr[3:0];
            r.disk_command = dc;
            r.disk_page = pg;
            r.last = lst;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void drop_recent(int fr);
            for (int i = 0; i < recency_len; i++)
            begin
                if (recency[i] == fr)
                begin
                    for (int j = i; j + 1 < recency_len; j++)
                        recency[j] = recency[j + 1];
                    recency_len--;
                    return;
                end
            end
        endfunction

        // Predict the results of one accepted request
        function void note_request(logic [bpfm_pkg::OP_W-1:0] op,
                                   logic [bpfm_pkg::PAGE_W-1:0] pg, bit md);
            int f;
            int fr;
            int n;
            int unsigned cap;
            f = -1;
            n = 0;
            cap = (frames_allowed < 16) ? frames_allowed : 16;
            for (int i = 0; i < 16; i++)
                if (f < 0 && resident[i] && page_of[i] == pg)
                    f = i;
            if (op == bpfm_pkg::OP_FETCH)
            begin
                if (f >= 0)
                begin
                    if (pins[f] >= 65535)
                    begin
                        push(bpfm_pkg::ST_PINERR, f, bpfm_pkg::DC_NONE, 0, 1);
                        return;
                    end
                    if (pins[f] == 0)
                        drop_recent(f);
                    pins[f]++;
                    push(bpfm_pkg::ST_HIT, f, bpfm_pkg::DC_NONE, 0, 1);
                    return;
                end
                if (handed_out < cap)
                begin
                    fr = handed_out;
                    handed_out++;
                end
                else if (recency_len > 0)
                begin
                    fr = recency[recency_len - 1];
                    recency_len--;
                    if (resident[fr] && dirty[fr])
                        push(bpfm_pkg::ST_LOADED, fr, bpfm_pkg::DC_WRITE, page_of[fr], 0);
                end
                else
                begin
                    push(bpfm_pkg::ST_NOFRAME, 0, bpfm_pkg::DC_NONE, 0, 1);
                    return;
                end
                page_of[fr] = pg;
                resident[fr] = 1;
                pins[fr] = 1;
                dirty[fr] = 0;
                push(bpfm_pkg::ST_LOADED, fr, bpfm_pkg::DC_READ, pg, 1);
            end
            else if (op == bpfm_pkg::OP_FLUSH_ALL)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    if (resident[i] && dirty[i])
                    begin
                        dirty[i] = 0;
                        push(bpfm_pkg::ST_DONE, i, bpfm_pkg::DC_WRITE, page_of[i], 0);
                        n++;
                    end
                end
                if (n == 0)
                    push(bpfm_pkg::ST_DONE, 0, bpfm_pkg::DC_NONE, 0, 1);
                else
                    pending_results[pending_results.size() - 1].last = 1;
            end
            else if (f < 0)
                push(bpfm_pkg::ST_NOTRES, 0, bpfm_pkg::DC_NONE, 0, 1);
            else if (op == bpfm_pkg::OP_UNPIN)
            begin
                if (md)
                    dirty[f] = 1;
                if (pins[f] == 0)
                begin
                    push(bpfm_pkg::ST_PINERR, f, bpfm_pkg::DC_NONE, 0, 1);
                    return;
                end
                pins[f]--;
                if (pins[f] == 0 && recency_len < 16)
                begin
                    for (int j = recency_len; j > 0; j--)
                        recency[j] = recency[j - 1];
                    recency[0] = f;
                    recency_len++;
                end
                push(bpfm_pkg::ST_DONE, f, bpfm_pkg::DC_NONE, 0, 1);
            end
            else
            begin
                if (dirty[f])
                begin
                    dirty[f] = 0;
                    push(bpfm_pkg::ST_DONE, f, bpfm_pkg::DC_WRITE, pg, 1);
                end
                else
                    push(bpfm_pkg::ST_DONE, f, bpfm_pkg::DC_NONE, 0, 1);
            end
        endfunction

        // Compare one result transaction with the oldest expectation
        function void check_result(page_result_t got);
            page_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, got);
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (got.status !== want.status || got.frame_index !== want.frame_index ||
                got.disk_command !== want.disk_command ||
                got.disk_page !== want.disk_page || got.last !== want.last)
            begin
                errors++;
                $display("%0t: mismatch expected %p actual %p", $time, want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [bpfm_pkg::APB_AW-1:0] paddr;
    logic [bpfm_pkg::APB_DW-1:0] pwdata;
    logic [bpfm_pkg::APB_DW-1:0] prdata;
    logic pready;

    bpfm_req_if req ();
    bpfm_rsp_if rsp ();

    buffer_pool_frame_manager_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req.sink),
        .rsp     (rsp.source)
    );

    localparam int WATCHDOG_LIMIT = 40000;

    frame_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned quiet_cycles;
    logic [bpfm_pkg::PAGE_W-1:0] fetched_pages[$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receive results, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
                sb.check_result('{rsp.status, rsp.frame_index, rsp.disk_command,
                                  rsp.disk_page, rsp.last});
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Count cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Write one register through the APB port
    task automatic write_frames(int unsigned v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {bpfm_pkg::REG_FRAMES_IN_USE, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_frames(v);
    endtask

    // Drain all outstanding results, then let the core settle
    task automatic wait_idle();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Send one request transaction, with an optional random gap first
    task automatic send_request(logic [bpfm_pkg::OP_W-1:0] op,
                                logic [bpfm_pkg::PAGE_W-1:0] pg, bit md);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= op;
        req.page_id <= pg;
        req.mark_dirty <= md;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(op, pg, md);
        if (op == bpfm_pkg::OP_FETCH)
            fetched_pages.insert(fetched_pages.size(), pg);
    endtask

    task automatic end_burst();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random well-formed traffic over a small page set, with some noise
    task automatic random_phase(int count, int pages);
        logic [bpfm_pkg::OP_W-1:0] op;
        logic [bpfm_pkg::PAGE_W-1:0] pg;
        int unsigned roll;
        int k;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            pg = 32'h0000_1000 + $urandom_range(pages - 1);
            if (roll < 45)
                op = bpfm_pkg::OP_FETCH;
            else if (roll < 80)
            begin
                op = bpfm_pkg::OP_UNPIN;
                if (fetched_pages.size() != 0 && $urandom_range(9) < 8)
                begin
                    k = $urandom_range(fetched_pages.size() - 1);
                    pg = fetched_pages[k];
                    fetched_pages.delete(k);
                end
            end
            else if (roll < 93)
                op = bpfm_pkg::OP_FLUSH;
            else
                op = bpfm_pkg::OP_FLUSH_ALL;
            if ($urandom_range(9) == 0)
                pg = $urandom;
            send_request(op, pg, $urandom_range(1));
        end
        end_burst();
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req.valid = 1'b0;
        req.opcode = bpfm_pkg::OP_FETCH;
        req.page_id = '0;
        req.mark_dirty = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: two frames, exhaustion, dirty eviction, pin errors, flushes
        write_frames(2);
        send_request(bpfm_pkg::OP_FLUSH_ALL, 32'h0, 0);
        send_request(bpfm_pkg::OP_FETCH, 32'h0000_0000, 0);
        send_request(bpfm_pkg::OP_FETCH, 32'hFFFF_FFFF, 0);
        send_request(bpfm_pkg::OP_FETCH, 32'h0000_0000, 1);
        send_request(bpfm_pkg::OP_FETCH, 32'h5555_AAAA, 0);
        send_request(bpfm_pkg::OP_UNPIN, 32'h0000_0000, 0);
        send_request(bpfm_pkg::OP_UNPIN, 32'h0000_0000, 1);
        send_request(bpfm_pkg::OP_UNPIN, 32'h0000_0000, 0);
        send_request(bpfm_pkg::OP_UNPIN, 32'hAAAA_5555, 0);
        send_request(bpfm_pkg::OP_FLUSH, 32'hAAAA_5555, 0);
        send_request(bpfm_pkg::OP_FETCH, 32'hAAAA_5555, 0);
        send_request(bpfm_pkg::OP_UNPIN, 32'hFFFF_FFFF, 1);
        send_request(bpfm_pkg::OP_FLUSH, 32'hFFFF_FFFF, 0);
        send_request(bpfm_pkg::OP_FLUSH, 32'hFFFF_FFFF, 0);
        send_request(bpfm_pkg::OP_UNPIN, 32'hAAAA_5555, 1);
        send_request(bpfm_pkg::OP_UNPIN, 32'hFFFF_FFFF, 1);
        send_request(bpfm_pkg::OP_FLUSH_ALL, 32'h0, 0);
        send_request(bpfm_pkg::OP_FETCH, 32'h1234_5678, 0);
        send_request(bpfm_pkg::OP_FETCH, 32'h8765_4321, 0);
        send_request(bpfm_pkg::OP_FETCH, 32'h0BAD_F00D, 0);
        end_burst();
        wait_idle();

        // Random phases over several pool sizes and idling patterns
        fetched_pages.delete();
        write_frames(16);
        random_phase(80, 24);
        wait_idle();
        write_frames(3);
        send_idle_pct = 68;
        random_phase(80, 8);
        wait_idle();
        write_frames(1);
        send_idle_pct = 0;
        recv_stall_pct = 68;
        random_phase(80, 6);
        wait_idle();
        write_frames(31);
        send_idle_pct = 12;
        recv_stall_pct = 12;
        random_phase(80, 40);
        wait_idle();

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bpfm_pkg.sv
hw/rtl/bpfm_if.sv
hw/rtl/bpfm_ctrl.sv
hw/rtl/bpfm_dp.sv
hw/rtl/buffer_pool_frame_manager_core.sv
hw/rtl/bpfm_checker.sv
bench/tb.sv
